FILE: hdl/e2q_pkg.sv
`default_nettype none
package e2q_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int COMP_BITS  = 16;

   // quarter-turn argument, 2^23 stands for pi/2
   localparam int ARG_BITS   = 24;
   localparam int ARG_FRAC   = 23;
   localparam int MAG_BITS   = 31;   // Q30 magnitude incl. slight overshoot
   localparam int FRAC_BITS  = 30;
   localparam int SUM_BITS   = 34;
   localparam int OUT_SHIFT  = FRAC_BITS - (COMP_BITS - 1);

   localparam logic [ARG_BITS-1:0] QUARTER_TURN = ARG_BITS'(1) << ARG_FRAC;

   localparam logic [MAG_BITS-1:0] SIN_C1 = 31'd1686629713;
   localparam logic [MAG_BITS-1:0] SIN_C3 = 31'd693598668;
   localparam logic [MAG_BITS-1:0] SIN_C5 = 31'd85569305;
   localparam logic [MAG_BITS-1:0] SIN_C7 = 31'd5026996;
   localparam logic [MAG_BITS-1:0] SIN_C9 = 31'd172272;

   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = 2;

   typedef struct packed {
      logic [ARG_BITS-1:0] u_h;
      logic [ARG_BITS-1:0] u_p;
      logic [ARG_BITS-1:0] u_b;
      logic                neg_h;
      logic                neg_p;
      logic                neg_b;
      logic                dir;
   } item_type;

endpackage
`default_nettype wire

FILE: hdl/e2q_front.sv
`default_nettype none
module e2q_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [47:0]                   req_tdata,
   input  wire logic                          dir,
   output logic                               q_valid,
   output e2q_pkg::item_type                  q_item,
   input  wire logic                          q_pop
);
   import e2q_pkg::*;

   item_type                  mem_ff [QDEPTH];
   logic [QPTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]        count_ff, count_in;
   item_type                  dec;
   logic                      push;

   function automatic logic [ARG_BITS:0] half_arg(input logic [ANGLE_BITS-1:0] a);
      logic [ANGLE_BITS-1:0] mag;
      logic [ARG_BITS-1:0]   u;
      mag = a[ANGLE_BITS-1] ? (~a + ANGLE_BITS'(1)) : a;
      u = ARG_BITS'(mag) << (ARG_BITS - ANGLE_BITS);
      return {a[ANGLE_BITS-1], u};
   endfunction

   always_comb begin
      logic [ARG_BITS:0] h, p, b;
      h = half_arg(req_tdata[ANGLE_BITS-1:0]);
      p = half_arg(req_tdata[2*ANGLE_BITS-1:ANGLE_BITS]);
      b = half_arg(req_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]);
      dec.u_h   = h[ARG_BITS-1:0];
      dec.neg_h = h[ARG_BITS];
      dec.u_p   = p[ARG_BITS-1:0];
      dec.neg_p = p[ARG_BITS];
      dec.u_b   = b[ARG_BITS-1:0];
      dec.neg_b = b[ARG_BITS];
      dec.dir   = dir;
   end

   assign req_tready = (count_ff != (QPTR_BITS+1)'(QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_item     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= dec;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != '0) else $error("pop from empty queue");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_BITS+1)'(QDEPTH)) else $error("queue overflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count mismatch");

endmodule
`default_nettype wire

FILE: hdl/e2q_sine.sv
`default_nettype none
module e2q_sine (
   input  wire logic                          clock,
   input  wire logic                          adv,
   input  wire logic [e2q_pkg::ARG_BITS-1:0]  t_in,
   output logic      [e2q_pkg::MAG_BITS-1:0]  sin_out
);
   import e2q_pkg::*;

   localparam int PW = ARG_BITS + MAG_BITS;

   logic [ARG_BITS-1:0] t_ff  [5];
   logic [ARG_BITS-1:0] t2_ff [4];
   logic [MAG_BITS-1:0] r_ff  [1:4];
   logic [MAG_BITS-1:0] s_ff;
   logic [2*ARG_BITS-1:0] sq;
   logic [PW-1:0]       hp [1:4];
   logic [PW-1:0]       fin;

   always_comb begin
      sq    = (2*ARG_BITS)'(t_in) * (2*ARG_BITS)'(t_in);
      hp[1] = PW'(t2_ff[0]) * PW'(SIN_C9);
      hp[2] = PW'(t2_ff[1]) * PW'(r_ff[1]);
      hp[3] = PW'(t2_ff[2]) * PW'(r_ff[2]);
      hp[4] = PW'(t2_ff[3]) * PW'(r_ff[3]);
      fin   = PW'(t_ff[4]) * PW'(r_ff[4]);
   end

   // horner steps, one multiply per stage
   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff[0]  <= t_in;
         t2_ff[0] <= sq[ARG_FRAC+ARG_BITS-1:ARG_FRAC];
         for (int i = 1; i < 4; i++) begin
            t2_ff[i] <= t2_ff[i-1];
         end
         for (int i = 1; i < 5; i++) begin
            t_ff[i] <= t_ff[i-1];
         end
         r_ff[1] <= SIN_C7 - hp[1][ARG_FRAC+MAG_BITS-1:ARG_FRAC];
         r_ff[2] <= SIN_C5 - hp[2][ARG_FRAC+MAG_BITS-1:ARG_FRAC];
         r_ff[3] <= SIN_C3 - hp[3][ARG_FRAC+MAG_BITS-1:ARG_FRAC];
         r_ff[4] <= SIN_C1 - hp[4][ARG_FRAC+MAG_BITS-1:ARG_FRAC];
         s_ff    <= fin[ARG_FRAC+MAG_BITS-1:ARG_FRAC];
      end
   end

   assign sin_out = s_ff;

endmodule
`default_nettype wire

FILE: hdl/e2q_back.sv
`default_nettype none
module e2q_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  wire e2q_pkg::item_type    q_item,
   output logic                      q_pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [63:0]               rsp_tdata
);
   import e2q_pkg::*;

   localparam int SINE_LAT = 6;
   localparam int NSTG     = SINE_LAT + 3;
   localparam int PP       = 2 * MAG_BITS;

   logic                 adv;
   logic [NSTG-1:0]      vld_ff;
   logic                 out_vld_ff;
   logic [3:0]           side_ff [SINE_LAT+1];   // neg_h, neg_p, neg_b, dir
   logic [MAG_BITS-1:0]  sh, ch, sp, cp, sb, cb;
   logic [MAG_BITS-1:0]  pm_ff [4];
   logic [MAG_BITS:0]    tr_ff [8];
   logic                 dir_tr_ff;
   logic [SUM_BITS-1:0]  sum_ff [4];
   logic [COMP_BITS-1:0] out_ff [4];
   logic [MAG_BITS-1:0]  pm_in [4];
   logic [MAG_BITS:0]    tr_in [8];
   logic [SUM_BITS-1:0]  sum_in [4];
   logic [COMP_BITS-1:0] out_in [4];
   // bank sine and cosine wait one stage for the pair products
   logic [MAG_BITS-1:0]  sb_d_ff, cb_d_ff;

   assign adv   = !out_vld_ff || rsp_tready;
   assign q_pop = adv && q_valid;

   e2q_sine u_sh (.clock, .adv, .t_in(q_item.u_h), .sin_out(sh));
   e2q_sine u_ch (.clock, .adv, .t_in(QUARTER_TURN - q_item.u_h), .sin_out(ch));
   e2q_sine u_sp (.clock, .adv, .t_in(q_item.u_p), .sin_out(sp));
   e2q_sine u_cp (.clock, .adv, .t_in(QUARTER_TURN - q_item.u_p), .sin_out(cp));
   e2q_sine u_sb (.clock, .adv, .t_in(q_item.u_b), .sin_out(sb));
   e2q_sine u_cb (.clock, .adv, .t_in(QUARTER_TURN - q_item.u_b), .sin_out(cb));

   function automatic logic [MAG_BITS-1:0] qmul(input logic [MAG_BITS-1:0] a,
                                                input logic [MAG_BITS-1:0] b);
      logic [PP:0] p;
      p = (PP+1)'(a) * (PP+1)'(b) + ((PP+1)'(1) << (FRAC_BITS - 1));
      return p[FRAC_BITS+MAG_BITS-1:FRAC_BITS];
   endfunction

   function automatic logic [MAG_BITS:0] signed_of(input logic [MAG_BITS-1:0] m,
                                                   input logic neg);
      return neg ? -(MAG_BITS+1)'(m) : (MAG_BITS+1)'(m);
   endfunction

   function automatic logic [SUM_BITS-1:0] sx(input logic [MAG_BITS:0] v);
      return SUM_BITS'($signed(v));
   endfunction

   function automatic logic [COMP_BITS-1:0] to_out(input logic [SUM_BITS-1:0] v);
      logic                neg;
      logic [SUM_BITS-1:0] mag;
      logic [SUM_BITS-1:0] lim;
      neg = v[SUM_BITS-1];
      mag = neg ? -v : v;
      mag = (mag + (SUM_BITS'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
      lim = SUM_BITS'(1) << (COMP_BITS - 1);
      if (neg) begin
         if (mag > lim) mag = lim;
         return -mag[COMP_BITS-1:0];
      end
      if (mag > lim - 1'b1) mag = lim - 1'b1;
      return mag[COMP_BITS-1:0];
   endfunction

   always_comb begin
      // pair products: ch*cp, sh*sp, ch*sp, sh*cp
      pm_in[0] = qmul(ch, cp);
      pm_in[1] = qmul(sh, sp);
      pm_in[2] = qmul(ch, sp);
      pm_in[3] = qmul(sh, cp);
   end

   always_comb begin
      logic ah, ap, ab;
      ah = side_ff[SINE_LAT][3];
      ap = side_ff[SINE_LAT][2];
      ab = side_ff[SINE_LAT][1];
      tr_in[0] = signed_of(qmul(pm_ff[0], cb_d_ff), 1'b0);
      tr_in[1] = signed_of(qmul(pm_ff[1], sb_d_ff), ah ^ ap ^ ab);
      tr_in[2] = signed_of(qmul(pm_ff[2], cb_d_ff), ap);
      tr_in[3] = signed_of(qmul(pm_ff[3], sb_d_ff), ah ^ ab);
      tr_in[4] = signed_of(qmul(pm_ff[3], cb_d_ff), ah);
      tr_in[5] = signed_of(qmul(pm_ff[2], sb_d_ff), ap ^ ab);
      tr_in[6] = signed_of(qmul(pm_ff[0], sb_d_ff), ab);
      tr_in[7] = signed_of(qmul(pm_ff[1], cb_d_ff), ah ^ ap);
   end

   always_comb begin
      logic [SUM_BITS-1:0] x, y, z;
      sum_in[0] = sx(tr_ff[0]) + sx(tr_ff[1]);
      x         = sx(tr_ff[2]) + sx(tr_ff[3]);
      y         = sx(tr_ff[4]) - sx(tr_ff[5]);
      z         = sx(tr_ff[6]) - sx(tr_ff[7]);
      sum_in[1] = dir_tr_ff ? -x : x;
      sum_in[2] = dir_tr_ff ? -y : y;
      sum_in[3] = dir_tr_ff ? -z : z;
      for (int i = 0; i < 4; i++) begin
         out_in[i] = to_out(sum_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[NSTG-2:0], q_valid};
         out_vld_ff <= vld_ff[NSTG-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= {q_item.neg_h, q_item.neg_p, q_item.neg_b, q_item.dir};
         for (int i = 1; i <= SINE_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         for (int i = 0; i < 4; i++) begin
            pm_ff[i] <= pm_in[i];
         end
         sb_d_ff <= sb;
         cb_d_ff <= cb;
         for (int i = 0; i < 8; i++) begin
            tr_ff[i] <= tr_in[i];
         end
         dir_tr_ff <= side_ff[SINE_LAT][0];
         for (int i = 0; i < 4; i++) begin
            sum_ff[i] <= sum_in[i];
            out_ff[i] <= out_in[i];
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_ff[3], out_ff[2], out_ff[1], out_ff[0]};

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_tready) |=> $stable(vld_ff)) else $error("pipeline moved on stall");
   a_out_src: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(vld_ff[NSTG-1])) else $error("result without item");
   a_pop_adv: assert property (@(posedge clock) disable iff (reset)
      (q_valid && adv) |=> vld_ff[0]) else $error("popped item lost");

endmodule
`default_nettype wire

FILE: hdl/euler_to_quaternion.sv
// throughput: one request per cycle while rsp_tready holds no stall, set by the fully
// pipelined sine units and the one-multiply-per-stage product tree; a 4-entry queue
// sits between front and back; reset (synchronous, active high) clears the queue,
// all valid bits and the direction register (object to inertial)
`default_nettype none
module euler_to_quaternion (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // heading_angle, pitch_angle, bank_angle
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // comp_w, comp_x, comp_y, comp_z
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);
   import e2q_pkg::*;

   logic     dir_ff;
   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= 1'b0;
      end else if (csr_wr_en) begin
         dir_ff <= csr_wr_data;
      end
   end

   e2q_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .dir(dir_ff), .q_valid, .q_item, .q_pop
   );

   e2q_back u_back (
      .clock, .reset, .q_valid, .q_item, .q_pop,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

endmodule
`default_nettype wire

FILE: sim/quat_checker.sv
`default_nettype none
module quat_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [47:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   output int               fail_count,
   output int               quats_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import e2q_pkg::*;

   typedef struct packed {
      logic signed [COMP_BITS-1:0] z;
      logic signed [COMP_BITS-1:0] y;
      logic signed [COMP_BITS-1:0] x;
      logic signed [COMP_BITS-1:0] w;
   } quat_type;

   typedef longint unsigned u64_type;

   quat_type expected_quats[$];
   logic     inverse_dir;

   function automatic longint quarter_sin(u64_type t);
      u64_type t2, r;
      t2 = (t * t) >> 23;
      r = u64_type'(SIN_C9);
      r = u64_type'(SIN_C7) - ((t2 * r) >> 23);
      r = u64_type'(SIN_C5) - ((t2 * r) >> 23);
      r = u64_type'(SIN_C3) - ((t2 * r) >> 23);
      r = u64_type'(SIN_C1) - ((t2 * r) >> 23);
      return longint'((t * r) >> 23);
   endfunction

   function automatic void half_sincos(logic signed [ANGLE_BITS-1:0] a,
                                       output longint s, output longint c);
      longint  av;
      u64_type u;
      av = longint'(a);
      u = u64_type'(av < 0 ? -av : av) << (24 - ANGLE_BITS);
      s = quarter_sin(u);
      if (av < 0) s = -s;
      c = quarter_sin(u64_type'(QUARTER_TURN) - u);
   endfunction

   function automatic longint q30_mul(longint p, longint q);
      logic    neg;
      u64_type mp, mq, r;
      neg = (p < 0) != (q < 0);
      mp = u64_type'(p < 0 ? -p : p);
      mq = u64_type'(q < 0 ? -q : q);
      r = (mp * mq + (u64_type'(1) << 29)) >> 30;
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint mul3(longint a, longint b, longint c);
      return q30_mul(q30_mul(a, b), c);
   endfunction

   function automatic logic [COMP_BITS-1:0] round_sat(longint v);
      u64_type mag, lim;
      logic    neg;
      neg = v < 0;
      mag = u64_type'(neg ? -v : v);
      lim = u64_type'(1) << (COMP_BITS - 1);
      mag = (mag + (u64_type'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
      if (neg) begin
         if (mag > lim) mag = lim;
         return COMP_BITS'(-longint'(mag));
      end
      if (mag > lim - 1) mag = lim - 1;
      return COMP_BITS'(mag);
   endfunction

   function automatic quat_type euler_quat(logic [47:0] angles, logic inv);
      longint   sh, ch, sp, cp, sb, cb, qw, qx, qy, qz;
      quat_type q;
      half_sincos(angles[15:0], sh, ch);
      half_sincos(angles[31:16], sp, cp);
      half_sincos(angles[47:32], sb, cb);
      qw = mul3(ch, cp, cb) + mul3(sh, sp, sb);
      qx = mul3(ch, sp, cb) + mul3(sh, cp, sb);
      qy = mul3(sh, cp, cb) - mul3(ch, sp, sb);
      qz = mul3(ch, cp, sb) - mul3(sh, sp, cb);
      if (inv) begin
         qx = -qx;
         qy = -qy;
         qz = -qz;
      end
      q.w = round_sat(qw);
      q.x = round_sat(qx);
      q.y = round_sat(qy);
      q.z = round_sat(qz);
      return q;
   endfunction

   initial begin
      fail_count = 0;
      quats_pending = 0;
      inverse_dir = 1'b0;
   end

   always @(posedge clock) begin
      quat_type got, want;
      if (reset) begin
         inverse_dir = 1'b0;
         expected_quats.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_quats.push_back(euler_quat(req_tdata, inverse_dir));
         if (csr_wr_en)
            inverse_dir = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_quats.size() == 0) begin
               $error("quaternion with no request waiting: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_quats.pop_front();
               if (got.w !== want.w) begin
                  $error("comp_w expected %0d got %0d", want.w, got.w);
                  fail_count++;
               end
               if (got.x !== want.x) begin
                  $error("comp_x expected %0d got %0d", want.x, got.x);
                  fail_count++;
               end
               if (got.y !== want.y) begin
                  $error("comp_y expected %0d got %0d", want.y, got.y);
                  fail_count++;
               end
               if (got.z !== want.z) begin
                  $error("comp_z expected %0d got %0d", want.z, got.z);
                  fail_count++;
               end
            end
         end
      end
      quats_pending = expected_quats.size();
   end
endmodule
`default_nettype wire

FILE: sim/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [63:0] rsp_tdata;
   logic        csr_wr_en, csr_wr_data;
   int          fail_count, quats_pending;
   int          rx_cycles;

   euler_to_quaternion DUT (.*);

   quat_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off to back up the pipeline
   initial begin
      int gap;
      rsp_tready = 1'b0;
      rx_cycles = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rx_cycles > 400 && rx_cycles < 420) begin
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
            rx_cycles = 420;
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         rx_cycles += 12;
         if ($urandom_range(0, 3) != 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   task automatic send_angles(logic [15:0] h, logic [15:0] p, logic [15:0] b,
                              bit no_gaps);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {b, p, h};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      gap = no_gaps ? 0 :
            ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic set_direction(logic inv);
      req_tvalid <= 1'b0;
      while (quats_pending != 0) @(negedge clock);
      repeat (15) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= inv;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(int'($urandom_range(0, 8)) - 4);
         3: return 16'h4000 ^ 16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] corner[8];
      logic        dir_seq[4];
      bit          burst;
      corner = '{16'h0000, 16'h7fff, 16'h8000, 16'h4000, 16'hc000, 16'h0001,
                 16'hffff, 16'h2000};
      dir_seq = '{1'b0, 1'b1, 1'b0, 1'b1};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int d = 0; d < 2; d++) begin
         set_direction(dir_seq[d]);
         for (int i = 0; i < 8; i++)
            send_angles(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8], 1'b0);
         send_angles(16'h8000, 16'h8000, 16'h8000, 1'b0);
         send_angles(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
         send_angles(16'h0000, 16'h0000, 16'h8000, 1'b0);
      end

      for (int d = 0; d < 4; d++) begin
         set_direction(dir_seq[d]);
         for (int i = 0; i < 170; i++) begin
            if (i % 40 == 0) burst = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 1) == 0)
               send_angles(16'($urandom), 16'($urandom), 16'($urandom), burst);
            else
               send_angles(pick_angle(), pick_angle(), pick_angle(), burst);
         end
      end

      req_tvalid <= 1'b0;
      while (quats_pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
hdl/e2q_pkg.sv
hdl/e2q_front.sv
hdl/e2q_sine.sv
hdl/e2q_back.sv
hdl/euler_to_quaternion.sv
sim/quat_checker.sv
sim/testbench.sv
